// File: sv/pdrf_pkg.sv
`default_nettype none
package pdrf_pkg;

  localparam int COLUMNS = 128;
  localparam int PAGES   = 8;
  localparam int ROWS    = PAGES * 8;
  localparam int CHUNK   = 32;
  localparam int DEPTH   = PAGES * COLUMNS;

  // input and output field widths
  localparam int X_W   = 7;
  localparam int Y_W   = 6;
  localparam int LEN_W = 8;
  localparam int H_W   = 7;
  localparam int CNT_W = 6;
  localparam int WORD_W = 64;

  // internal widths
  localparam int CL_W     = 9;   // column clamp arithmetic, holds COLUMNS
  localparam int RW_W     = 8;   // row arithmetic, holds ROWS
  localparam int PAGE_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CIDX_W   = $clog2(COLUMNS);
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int IDX_W    = $clog2(CHUNK);
  localparam int CHUNK_BW = CHUNK * 8;

  // command bytes
  localparam logic [7:0] CMD_PAGE  = 8'hB0;
  localparam logic [7:0] CMD_COLHI = 8'h10;
  localparam logic [7:0] NIB_MASK  = 8'h0F;
  localparam logic [7:0] FULL_MASK = 8'hFF;
  localparam logic [CNT_W-1:0] CMD_LEN = CNT_W'(3);

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [X_W-1:0]    col;
    logic [LEN_W-1:0]  len;
    logic [7:0]        mask;
    logic              last;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

endpackage
`default_nettype wire

// File: sv/pdrf_if.sv
`default_nettype none
interface pdrf_in_if;
  import pdrf_pkg::*;
  logic             valid;
  logic             ready;
  logic [X_W-1:0]   col_start;
  logic [Y_W-1:0]   row_start;
  logic [LEN_W-1:0] col_count;
  logic [H_W-1:0]   row_count;

  modport source (output valid, col_start, row_start, col_count, row_count, input ready);
  modport sink   (input valid, col_start, row_start, col_count, row_count, output ready);
endinterface

interface pdrf_out_if;
  import pdrf_pkg::*;
  logic              valid;
  logic              ready;
  logic              is_data;
  logic [CNT_W-1:0]  byte_count;
  logic [WORD_W-1:0] bytes_word0;
  logic [WORD_W-1:0] bytes_word1;
  logic [WORD_W-1:0] bytes_word2;
  logic [WORD_W-1:0] bytes_word3;
  logic              last;

  modport source (output valid, is_data, byte_count, bytes_word0, bytes_word1,
                  bytes_word2, bytes_word3, last, input ready);
  modport sink   (input valid, is_data, byte_count, bytes_word0, bytes_word1,
                  bytes_word2, bytes_word3, last, output ready);
endinterface
`default_nettype wire

// File: sv/page_display_rectangle_fill.sv
`default_nettype none
// channel  dir  fields                                              role
// in_ch    in   col_start row_start col_count row_count             rectangle request
// out_ch   out  is_data byte_count bytes_word0..3 last              command/pixel chunk
//
// after reset the frame store is swept to zero, all 1024 bytes, with in_ch.ready low
// the front clamps a request and queues one job per touched page, one a cycle
// while the queue has room; the back emits 1 command chunk per page, then walks the
// columns one byte a cycle, reading and writing back through separate store ports
// an output stall holds the back, and once the two-job queue fills the front and
// in_ch.ready wait as well
module page_display_rectangle_fill (
  input  wire logic clk,
  input  wire logic rst_n,
  pdrf_in_if.sink   in_ch,
  pdrf_out_if.source out_ch
);
  import pdrf_pkg::*;

  push_t push;
  job_t  q_job;
  logic  q_full, q_empty, q_pop, store_ready;

  pdrf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .store_ready (store_ready),
    .q_full      (q_full),
    .push        (push)
  );

  pdrf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (q_full),
    .pop     (q_pop),
    .pop_job (q_job),
    .empty   (q_empty)
  );

  pdrf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_job       (q_job),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .store_ready (store_ready),
    .out_ch      (out_ch)
  );

endmodule
`default_nettype wire

// File: sv/pdrf_front.sv
`default_nettype none
module pdrf_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  pdrf_in_if.sink            in_ch,
  input  wire logic          store_ready,
  input  wire logic          q_full,
  output pdrf_pkg::push_t    push
);
  import pdrf_pkg::*;

  logic              busy_r, busy_nxt;
  logic [X_W-1:0]    x_r, x_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [RW_W-1:0]   top_r, top_nxt;
  logic [RW_W-1:0]   bot_r, bot_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;

  logic [CL_W-1:0]   x9, room, len9, lenc;
  logic [RW_W-1:0]   y8, hroom, h8, hc;
  logic              accept, keep;
  logic [PAGE_W-1:0] first_pg, last_pg;
  logic [2:0]        lo, hi;
  logic              is_last;

  assign in_ch.ready = !busy_r && store_ready;
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    x9    = CL_W'(in_ch.col_start);
    len9  = CL_W'(in_ch.col_count);
    room  = CL_W'(COLUMNS) - x9;
    lenc  = (len9 > room) ? room : len9;
    y8    = RW_W'(in_ch.row_start);
    h8    = RW_W'(in_ch.row_count);
    hroom = RW_W'(ROWS) - y8;
    hc    = (h8 > hroom) ? hroom : h8;
    keep  = (x9 < CL_W'(COLUMNS)) && (y8 < RW_W'(ROWS)) &&
            (lenc != '0) && (hc != '0);
  end

  // row mask and queue push of the current page
  always_comb begin
    first_pg = PAGE_W'(top_r >> 3);
    last_pg  = PAGE_W'(bot_r >> 3);
    is_last  = (page_r == last_pg);
    lo       = (page_r == first_pg) ? top_r[2:0] : 3'd0;
    hi       = is_last ? bot_r[2:0] : 3'd7;
    push.valid    = busy_r && !q_full;
    push.job.page = page_r;
    push.job.col  = x_r;
    push.job.len  = len_r;
    push.job.mask = (FULL_MASK << lo) & (FULL_MASK >> (3'd7 - hi));
    push.job.last = is_last;
  end

  always_comb begin
    busy_nxt = busy_r;
    x_nxt    = x_r;
    len_nxt  = len_r;
    top_nxt  = top_r;
    bot_nxt  = bot_r;
    page_nxt = page_r;
    if (accept && keep) begin
      busy_nxt = 1'b1;
      x_nxt    = in_ch.col_start;
      len_nxt  = LEN_W'(lenc);
      top_nxt  = y8;
      bot_nxt  = y8 + hc - RW_W'(1);
      page_nxt = PAGE_W'(y8 >> 3);
    end else if (push.valid) begin
      page_nxt = page_r + PAGE_W'(1);
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    x_r    <= x_nxt;
    len_r  <= len_nxt;
    top_r  <= top_nxt;
    bot_r  <= bot_nxt;
    page_r <= page_nxt;
  end

endmodule
`default_nettype wire

// File: sv/pdrf_queue.sv
`default_nettype none
module pdrf_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire pdrf_pkg::push_t push,
  output logic                full,
  input  wire logic           pop,
  output pdrf_pkg::job_t      pop_job,
  output logic                empty
);
  import pdrf_pkg::*;

  job_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign pop_job = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push.valid) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      unique case ({push.valid, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
    if (push.valid) begin
      slot_r[wp_r] <= push.job;
    end
  end

endmodule
`default_nettype wire

// File: sv/pdrf_back.sv
`default_nettype none
module pdrf_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pdrf_pkg::job_t q_job,
  input  wire logic          q_empty,
  output logic               q_pop,
  output logic               store_ready,
  pdrf_out_if.source         out_ch
);
  import pdrf_pkg::*;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_CMD  = 6'b000100,
    S_RD   = 6'b001000,
    S_WAIT = 6'b010000,
    S_PUT  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  job_t                job_r, job_nxt;
  logic [CIDX_W-1:0]   col_r, col_nxt;
  logic [LEN_W-1:0]    left_r, left_nxt;
  logic [CNT_W-1:0]    cn_r, cn_nxt;
  logic [IDX_W-1:0]    widx_r, widx_nxt;
  logic [CHUNK_BW-1:0] buf_r, buf_nxt;
  logic                rdv_r;
  logic [ADDR_W-1:0]   wa_r;

  logic                ov_r, ov_nxt;
  logic                od_r, od_nxt;
  logic [CNT_W-1:0]    oc_r, oc_nxt;
  logic [CHUNK_BW-1:0] ob_r, ob_nxt;
  logic                ol_r, ol_nxt;

  logic [7:0]          mem [DEPTH];
  logic [7:0]          mem_q;
  logic                we;
  logic [ADDR_W-1:0]   wa;
  logic [7:0]          wd;
  logic                rd_issue;
  logic [ADDR_W-1:0]   ra;
  logic                out_free;

  assign out_free    = !ov_r || out_ch.ready;
  assign store_ready = (state_r != S_CLR);
  assign ra = ADDR_W'(job_r.page) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);

  assign out_ch.valid       = ov_r;
  assign out_ch.is_data     = od_r;
  assign out_ch.byte_count  = oc_r;
  assign out_ch.bytes_word0 = ob_r[0 +: WORD_W];
  assign out_ch.bytes_word1 = ob_r[WORD_W +: WORD_W];
  assign out_ch.bytes_word2 = ob_r[2*WORD_W +: WORD_W];
  assign out_ch.bytes_word3 = ob_r[3*WORD_W +: WORD_W];
  assign out_ch.last        = ol_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    job_nxt   = job_r;
    col_nxt   = col_r;
    left_nxt  = left_r;
    cn_nxt    = cn_r;
    widx_nxt  = widx_r;
    buf_nxt   = buf_r;
    ov_nxt    = ov_r && !out_ch.ready;
    od_nxt    = od_r;
    oc_nxt    = oc_r;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    q_pop     = 1'b0;
    rd_issue  = 1'b0;
    we        = 1'b0;
    wa        = wa_r;
    wd        = mem_q | job_r.mask;

    // returning read: or in the mask, write back, collect into the chunk
    if (rdv_r) begin
      we       = 1'b1;
      buf_nxt[widx_r*8 +: 8] = wd;
      widx_nxt = widx_r + IDX_W'(1);
    end

    unique case (state_r)
      S_CLR: begin
        we      = 1'b1;
        wa      = clr_r;
        wd      = 8'h00;
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_job;
          col_nxt   = CIDX_W'(q_job.col);
          left_nxt  = q_job.len;
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = 1'b0;
          oc_nxt = CMD_LEN;
          ob_nxt = '0;
          ob_nxt[7:0]   = CMD_PAGE + 8'(job_r.page);
          ob_nxt[15:8]  = 8'(job_r.col) & NIB_MASK;
          ob_nxt[23:16] = CMD_COLHI | 8'(job_r.col >> 4);
          ol_nxt = 1'b0;
          cn_nxt = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        rd_issue = 1'b1;
        col_nxt  = col_r + CIDX_W'(1);
        left_nxt = left_r - LEN_W'(1);
        cn_nxt   = cn_r + CNT_W'(1);
        if (left_r == LEN_W'(1) || cn_r == CNT_W'(CHUNK - 1)) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          od_nxt   = 1'b1;
          oc_nxt   = cn_r;
          ob_nxt   = buf_r;
          ol_nxt   = job_r.last && (left_r == '0);
          buf_nxt  = '0;
          widx_nxt = '0;
          cn_nxt   = '0;
          state_nxt = (left_r == '0) ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    mem_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      rdv_r   <= 1'b0;
      ov_r    <= 1'b0;
      cn_r    <= '0;
      widx_r  <= '0;
      buf_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      rdv_r   <= rd_issue;
      ov_r    <= ov_nxt;
      cn_r    <= cn_nxt;
      widx_r  <= widx_nxt;
      buf_r   <= buf_nxt;
    end
    job_r  <= job_nxt;
    col_r  <= col_nxt;
    left_r <= left_nxt;
    wa_r   <= ra;
    od_r   <= od_nxt;
    oc_r   <= oc_nxt;
    ob_r   <= ob_nxt;
    ol_r   <= ol_nxt;
  end

endmodule
`default_nettype wire
